// ----- hw/rtl/pmc_pkg.sv -----
// Package for the mouse controller: shared types, constants and commands.
// No dependencies.
`default_nettype none
package pmc_pkg;
	localparam int BufDepth = 8;
	localparam int IdxW = 4;
	localparam logic [15:0] CoordMax = 16'd1023;

	typedef enum logic [2:0] {
		REQ_PA = 3'd0, REQ_PB = 3'd1, REQ_POS = 3'd2, REQ_BTN = 3'd3,
		REQ_VBL = 3'd4, REQ_RST = 3'd5
	} req_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DIV, ST_DWAIT, ST_DONE, ST_OUT
	} state_t;

	// datapath commands
	typedef struct packed {
		logic start;       // apply item, may request scaling
		logic div_go;      // start divider
		logic div_step;    // divider step
		logic place_fin;   // write scaled result and raise events
		logic out_load;    // capture result
	} cmd_t;

	typedef struct packed {
		logic need_place;
		logic div_done;
	} sts_t;
endpackage
`default_nettype wire

// ----- hw/rtl/pia_mouse_controller.sv -----
// Top level of the mouse controller: stream ports around controller and datapath.
// Depends on pmc_pkg, pmc_ctrl, pmc_dp.
`default_nettype none
// One transaction in, one out. When an item needs a placement and both ranges are
// nonzero, a 26-step restoring divider scales both axes in parallel.
// Input is taken again once the result transaction has been accepted.
module pia_mouse_controller (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// tdata: data_byte, host_x, host_y, host_range_x, host_range_y, button_index,
	// button_down, vblank_level
	input  wire logic [79:0] s_axis_tdata,
	// tuser: req_type
	input  wire logic [2:0]  s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// tdata: port_a_out, port_b_out, rom_bank, irq_level
	output logic [23:0]      m_axis_tdata
);
	import pmc_pkg::*;
	cmd_t cmd;
	sts_t sts;
	logic busy, fire;
	logic [19:0] res;

	assign s_axis_tready = !busy;
	assign fire = s_axis_tvalid && !busy;

	pmc_ctrl u_ctrl (
		.clk, .arst_n, .in_fire(fire), .out_taken(m_axis_tready), .sts, .cmd,
		.busy, .out_valid(m_axis_tvalid)
	);

	pmc_dp u_dp (
		.clk, .arst_n, .cmd, .item({s_axis_tdata[74:0], s_axis_tuser}), .sts,
		.result(res)
	);

	assign m_axis_tdata = {4'd0, res};
endmodule
`default_nettype wire

// ----- hw/rtl/pmc_ctrl.sv -----
// Controller state machine of the mouse controller.
// Depends on pmc_pkg.
`default_nettype none
module pmc_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_fire,
	input  wire logic           out_taken,
	input  wire pmc_pkg::sts_t  sts,
	output pmc_pkg::cmd_t       cmd,
	output logic                busy,
	output logic                out_valid
);
	import pmc_pkg::*;
	state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_n;
	end

	always_comb begin
		state_n = state_q;
		cmd = '0;
		busy = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (in_fire) begin
					cmd.start = 1'b1;
					state_n = ST_DIV;
				end
			end
			ST_DIV: begin
				if (sts.need_place) begin
					cmd.div_go = 1'b1;
					state_n = ST_DWAIT;
				end else state_n = ST_DONE;
			end
			ST_DWAIT: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) begin
					cmd.div_step = 1'b0;
					cmd.place_fin = 1'b1;
					state_n = ST_DONE;
				end
			end
			ST_DONE: begin
				cmd.out_load = 1'b1;
				state_n = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_taken) state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

// ----- hw/rtl/pmc_dp.sv -----
// Datapath of the mouse controller: ports, command buffer, mouse state,
// and a restoring divider for position scaling. Depends on pmc_pkg.
`default_nettype none
module pmc_dp (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire pmc_pkg::cmd_t cmd,
	input  wire logic [77:0]   item,
	output pmc_pkg::sts_t      sts,
	output logic [19:0]        result
);
	import pmc_pkg::*;

	logic [7:0] buf_q [BufDepth];
	logic [IdxW-1:0] idx_q, len_q;
	logic [3:0] mode_q;
	logic [7:0] stat_q, pa_q, pb_q, drv_q;
	logic [15:0] lx_q, ly_q, mnx_q, mxx_q, mny_q, mxy_q, rx_q, ry_q, srx_q, sry_q;
	logic [1:0] bnow_q, bbef_q;
	logic vbl_q, irq_q, place_q, ev_q;
	logic [15:0] px_q, py_q;
	logic [5:0] cnt_q;
	logic [25:0] rem_x_q, rem_y_q;
	logic [25:0] qx_q, qy_q;
	logic [19:0] res_q;

	logic [2:0] rq;
	logic [7:0] d;
	logic [15:0] hx, hy, hrx, hry;
	assign rq = item[2:0];
	assign d = item[10:3];
	assign hx = item[26:11];
	assign hy = item[42:27];
	assign hrx = item[58:43];
	assign hry = item[74:59];

	function automatic logic [15:0] fit(input logic [25:0] v, input logic [15:0] lo,
		input logic [15:0] hi);
		logic [25:0] t;
		t = v;
		if (t < {10'd0, lo}) t = {10'd0, lo};
		if (t > {10'd0, hi}) t = {10'd0, hi};
		return t[15:0];
	endfunction

	// event computation over a given next state
	function automatic logic [7:0] ev_bits(input logic [3:0] m, input logic moved,
		input logic bch, input logic vb);
		logic [7:0] e;
		e = '0;
		if (moved) begin
			e[5] = 1'b1;
			if (m[0] && m[1]) e[1] = 1'b1;
		end
		if (m[0]) begin
			if (bch && m[2]) e[2] = 1'b1;
			if (vb && m[3]) e[3] = 1'b1;
		end
		return e;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		logic [7:0] b0, st, e, b1;
		logic [IdxW-1:0] ix, ln;
		logic [3:0] md;
		logic [15:0] rx, ry, lo, hi, mnx, mxx, mny, mxy, lx, ly, px, py;
		logic [1:0] bb, bn;
		logic pl, evt, sr, vb;
		logic [7:0] bf [BufDepth];
		logic [7:0] drv, pb, df;
		if (!arst_n) begin
			for (int i = 0; i < BufDepth; i++) buf_q[i] <= '0;
			idx_q <= '0; len_q <= IdxW'(1); mode_q <= '0; stat_q <= '0;
			lx_q <= '0; ly_q <= '0; mnx_q <= '0; mny_q <= '0;
			mxx_q <= CoordMax; mxy_q <= CoordMax; rx_q <= '0; ry_q <= '0;
			srx_q <= '0; sry_q <= '0; bnow_q <= '0; bbef_q <= '0; vbl_q <= 1'b0;
			pa_q <= '0; pb_q <= 8'h40; drv_q <= '0; irq_q <= 1'b0;
			place_q <= 1'b0; ev_q <= 1'b0; px_q <= '0; py_q <= '0; cnt_q <= '0;
			rem_x_q <= '0; rem_y_q <= '0; qx_q <= '0; qy_q <= '0; res_q <= '0;
		end else begin
			if (cmd.start) begin
				for (int i = 0; i < BufDepth; i++) bf[i] = buf_q[i];
				ix = idx_q; ln = len_q; md = mode_q; st = stat_q;
				rx = rx_q; ry = ry_q; mnx = mnx_q; mxx = mxx_q; mny = mny_q; mxy = mxy_q;
				lx = lx_q; ly = ly_q; bb = bbef_q; bn = bnow_q; vb = vbl_q;
				drv = drv_q; pb = pb_q; pl = 1'b0; evt = 1'b0; sr = 1'b0;
				lo = '0; hi = '0; b1 = '0; b0 = '0; e = '0;
				px = '0; py = '0;
				case (rq)
					REQ_PA: pa_q <= d;
					REQ_PB: begin
						df = (pb ^ d) & 8'h3E;
						if (df != 8'h00) begin
							pb = (pb & 8'hC1) | (d & 8'h3E);
							if (df[5]) begin
								if (d[5]) pb[7] = 1'b1;
								else begin
									if (ix < IdxW'(BufDepth)) begin
										bf[ix[2:0]] = pa_q;
										ix = ix + 1'b1;
									end
									if (ix == IdxW'(1)) begin
										b0 = bf[0];
										case (b0[7:4])
											4'h0: begin
												ln = IdxW'(1); md = b0[3:0]; evt = 1'b1;
											end
											4'h1: begin
												ln = IdxW'(6); st = st & 8'h20; rx = lx; ry = ly;
												if (bb[0]) st[6] = 1'b1;
												if (bb[1]) st[0] = 1'b1;
												bb = bn;
												if (bb[0]) st[7] = 1'b1;
												if (bb[1]) st[4] = 1'b1;
												bf[1] = rx[7:0]; bf[2] = rx[15:8];
												bf[3] = ry[7:0]; bf[4] = ry[15:8];
												bf[5] = st; st[5] = 1'b0;
											end
											4'h2: begin
												ln = IdxW'(2); b1 = st; b1[5] = 1'b0; bf[1] = b1;
												irq_q <= 1'b0;
											end
											4'h3: sr = 1'b1;
											4'h4, 4'h6: ln = IdxW'(5);
											4'h5: begin ln = IdxW'(3); bf[1] = 8'hFF; end
											4'h7: begin
												ln = IdxW'(1); pl = 1'b1; evt = 1'b1;
											end
											4'h9: begin
												case (b0[3:2])
													2'd1: ln = IdxW'(3);
													2'd2: ln = IdxW'(2);
													2'd3: ln = IdxW'(4);
													default: ln = IdxW'(1);
												endcase
											end
											default: ln = IdxW'(1);
										endcase
										if (sr) begin
											ix = '0; ln = IdxW'(1); md = '0; st = '0; rx = '0;
											ry = '0; bb = '0; mnx = '0; mny = '0;
											mxx = CoordMax; mxy = CoordMax;
											lx = fit({10'd0, lx}, 16'd0, CoordMax);
											ly = fit({10'd0, ly}, 16'd0, CoordMax);
											pl = 1'b1;
										end
										drv = bf[1];
									end
									if (ix == ln || ix >= IdxW'(BufDepth)) begin
										lo = {bf[2], bf[1]};
										hi = {bf[4], bf[3]};
										case (bf[0][7:4])
											4'h6: if (lo <= hi) begin
												if (bf[0][0]) begin
													mny = lo; mxy = hi; ly = fit({10'd0, ly}, lo, hi);
												end else begin
													mnx = lo; mxx = hi; lx = fit({10'd0, lx}, lo, hi);
												end
											end
											4'h4: begin
												rx = lo; ry = hi; pl = 1'b1; evt = 1'b1;
												px = lo; py = hi;
											end
											4'h5: begin
												rx = '0; ry = '0; mnx = '0; mny = '0;
												mxx = CoordMax; mxy = CoordMax;
												lx = fit({10'd0, lx}, 16'd0, CoordMax);
												ly = fit({10'd0, ly}, 16'd0, CoordMax);
												pl = 1'b1; evt = 1'b1;
											end
											default: ;
										endcase
										ix = '0;
									end
									pb[7] = 1'b0;
								end
							end
							if (df[4]) begin
								if (d[4]) pb[6] = 1'b0;
								else begin
									if (ix != '0) ix = ix + 1'b1;
									if (ix == ln || ix >= IdxW'(BufDepth)) ix = '0;
									else drv = bf[ix[2:0]];
									pb[6] = 1'b1;
								end
							end
						end
					end
					REQ_POS: begin
						srx_q <= hrx; sry_q <= hry; px = hx; py = hy;
						pl = 1'b1; evt = 1'b1;
					end
					REQ_BTN: begin
						if (item[76]) bn[item[75]] = 1'b1; else bn[item[75]] = 1'b0;
						evt = 1'b1;
					end
					REQ_VBL: begin
						if (item[77] != vb) begin
							vb = item[77];
							if (item[77]) evt = 1'b1;
						end
					end
					REQ_RST: begin
						ix = '0; ln = IdxW'(1); md = '0; st = '0; rx = '0; ry = '0; bb = '0;
						mnx = '0; mny = '0; mxx = CoordMax; mxy = CoordMax;
						lx = fit({10'd0, lx}, 16'd0, CoordMax);
						ly = fit({10'd0, ly}, 16'd0, CoordMax);
						pl = 1'b1;
					end
					default: ;
				endcase
				if (rq == REQ_POS) pl = pl && hrx != '0 && hry != '0;
				else pl = pl && srx_q != '0 && sry_q != '0;
				// events before placement only if no placement follows
				if (evt && !pl) begin
					e = ev_bits(md, rx != lx || ry != ly, bb != bn, vb);
					st = st | e;
					if (e[3:1] != 3'd0) irq_q <= 1'b1;
				end
				for (int i = 0; i < BufDepth; i++) buf_q[i] <= bf[i];
				idx_q <= ix; len_q <= ln; mode_q <= md; stat_q <= st;
				rx_q <= rx; ry_q <= ry; mnx_q <= mnx; mxx_q <= mxx; mny_q <= mny;
				mxy_q <= mxy; lx_q <= lx; ly_q <= ly; bbef_q <= bb; bnow_q <= bn;
				vbl_q <= vb; drv_q <= drv; pb_q <= pb; place_q <= pl; ev_q <= evt;
				px_q <= px; py_q <= py;
			end
			if (cmd.div_go) begin
				rem_x_q <= '0; rem_y_q <= '0;
				qx_q <= 26'(px_q) * 26'(CoordMax);
				qy_q <= 26'(py_q) * 26'(CoordMax);
				cnt_q <= 6'd26;
			end
			if (cmd.div_step) begin
				logic [26:0] tx, ty;
				tx = {rem_x_q, qx_q[25]};
				ty = {rem_y_q, qy_q[25]};
				if (tx >= {11'd0, srx_q}) begin
					rem_x_q <= 26'(tx - {11'd0, srx_q}); qx_q <= {qx_q[24:0], 1'b1};
				end else begin
					rem_x_q <= tx[25:0]; qx_q <= {qx_q[24:0], 1'b0};
				end
				if (ty >= {11'd0, sry_q}) begin
					rem_y_q <= 26'(ty - {11'd0, sry_q}); qy_q <= {qy_q[24:0], 1'b1};
				end else begin
					rem_y_q <= ty[25:0]; qy_q <= {qy_q[24:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
			end
			if (cmd.place_fin) begin
				lx = fit(qx_q, mnx_q, mxx_q);
				ly = fit(qy_q, mny_q, mxy_q);
				lx_q <= lx; ly_q <= ly;
				if (ev_q) begin
					e = ev_bits(mode_q, rx_q != lx || ry_q != ly, bbef_q != bnow_q, vbl_q);
					stat_q <= stat_q | e;
					if (e[3:1] != 3'd0) irq_q <= 1'b1;
				end
			end
			if (cmd.out_load) res_q <= {irq_q, pb_q[3:1], pb_q, drv_q};
		end
	end

	assign sts.need_place = place_q;
	assign sts.div_done = (cnt_q == 6'd0);
	assign result = res_q;
endmodule
`default_nettype wire

// ----- tb/tb_pia_mouse_controller.sv -----
// Testbench for pia_mouse_controller: stream stimulus, scoreboard with a port-level predictor.
// Depends on pmc_pkg and the controller RTL.
`timescale 1ns / 1ps
`default_nettype none
import pmc_pkg::*;

class pmc_scoreboard;
	bit [7:0] cmd_buf [8];
	int unsigned idx, xfer_len, irq_mode, status;
	int unsigned live_x, live_y, min_x, max_x, min_y, max_y;
	int unsigned rep_x, rep_y, range_x, range_y;
	int unsigned btn_now, btn_prev, vbl_seen;
	int unsigned latch_a, shadow_b, irq, drive_a;
	logic [23:0] expected_q [$];
	int errors;

	function new();
		foreach (cmd_buf[i]) cmd_buf[i] = 0;
		live_x = 0; live_y = 0; range_x = 0; range_y = 0;
		btn_now = 0; vbl_seen = 0; latch_a = 0; shadow_b = 'h40;
		irq = 0; drive_a = 0; errors = 0;
		min_x = 0; min_y = 0; max_x = CoordMax; max_y = CoordMax;
		soft_reset();
	endfunction

	function int unsigned fit(longint unsigned v, int unsigned lo, int unsigned hi);
		if (v < lo) v = lo;
		if (v > hi) v = hi;
		return int'(v);
	endfunction

	function void clamp_axis(bit axis, int unsigned lo, int unsigned hi);
		if (lo > hi) return;
		if (axis) begin
			min_y = lo; max_y = hi; live_y = fit(live_y, lo, hi);
		end else begin
			min_x = lo; max_x = hi; live_x = fit(live_x, lo, hi);
		end
	endfunction

	function void place(int unsigned x, int unsigned y);
		longint unsigned sx, sy;
		if (range_x == 0 || range_y == 0) return;
		sx = (longint'(x) * CoordMax) / range_x;
		sy = (longint'(y) * CoordMax) / range_y;
		live_x = fit(sx, min_x, max_x);
		live_y = fit(sy, min_y, max_y);
	endfunction

	function void mouse_event();
		int unsigned ev;
		bit on;
		ev = 0;
		on = irq_mode[0];
		if (rep_x != live_x || rep_y != live_y) begin
			ev |= 'h20;
			if (on && irq_mode[1]) ev |= 'h02;
		end
		if (on) begin
			if (btn_prev != btn_now && irq_mode[2]) ev |= 'h04;
			if (vbl_seen != 0 && irq_mode[3]) ev |= 'h08;
		end
		status = (status | ev) & 'hFF;
		if (ev & 'h0E) irq = 1;
	endfunction

	function void soft_reset();
		idx = 0; xfer_len = 1; irq_mode = 0; status = 0;
		rep_x = 0; rep_y = 0; btn_prev = 0;
		clamp_axis(0, 0, CoordMax);
		clamp_axis(1, 0, CoordMax);
		place(0, 0);
	endfunction

	function void decode();
		int unsigned b0;
		b0 = cmd_buf[0];
		case (b0 & 'hF0)
			'h00: begin
				xfer_len = 1; irq_mode = b0 & 'h0F; mouse_event();
			end
			'h10: begin
				xfer_len = 6;
				status &= 'h20;
				rep_x = live_x; rep_y = live_y;
				if (btn_prev & 1) status |= 'h40;
				if (btn_prev & 2) status |= 'h01;
				btn_prev = btn_now;
				if (btn_prev & 1) status |= 'h80;
				if (btn_prev & 2) status |= 'h10;
				cmd_buf[1] = rep_x[7:0];
				cmd_buf[2] = rep_x[15:8];
				cmd_buf[3] = rep_y[7:0];
				cmd_buf[4] = rep_y[15:8];
				cmd_buf[5] = status[7:0];
				status &= 'hDF;
			end
			'h20: begin
				xfer_len = 2; cmd_buf[1] = status[7:0] & 8'hDF; irq = 0;
			end
			'h30: begin
				soft_reset(); xfer_len = 1;
			end
			'h40, 'h60: xfer_len = 5;
			'h50: begin
				xfer_len = 3; cmd_buf[1] = 8'hFF;
			end
			'h70: begin
				xfer_len = 1; place(0, 0); mouse_event();
			end
			'h90: begin
				case (b0 & 'h0C)
					'h04: xfer_len = 3;
					'h08: xfer_len = 2;
					'h0C: xfer_len = 4;
					default: xfer_len = 1;
				endcase
			end
			default: xfer_len = 1;
		endcase
		drive_a = cmd_buf[1];
	endfunction

	function void execute();
		int unsigned lo, hi;
		lo = {cmd_buf[2], cmd_buf[1]};
		hi = {cmd_buf[4], cmd_buf[3]};
		case (cmd_buf[0] & 8'hF0)
			8'h60: clamp_axis(cmd_buf[0][0], lo, hi);
			8'h40: begin
				rep_x = lo; rep_y = hi; place(lo, hi); mouse_event();
			end
			8'h50: begin
				rep_x = 0; rep_y = 0;
				clamp_axis(0, 0, CoordMax);
				clamp_axis(1, 0, CoordMax);
				place(0, 0);
				mouse_event();
			end
			default: ;
		endcase
	endfunction

	function void write_strobe(bit [7:0] d);
		if (d[5]) begin
			shadow_b |= 'h80;
			return;
		end
		if (idx < BufDepth) begin
			cmd_buf[idx] = latch_a[7:0];
			idx++;
		end
		if (idx == 1) decode();
		if (idx == xfer_len || idx >= BufDepth) begin
			execute();
			idx = 0;
		end
		shadow_b &= 'h7F;
	endfunction

	function void read_strobe(bit [7:0] d);
		if (d[4]) begin
			shadow_b &= 'hBF;
			return;
		end
		if (idx != 0) idx++;
		if (idx == xfer_len || idx >= BufDepth) idx = 0;
		else drive_a = cmd_buf[idx];
		shadow_b |= 'h40;
	endfunction

	function void port_b_write(bit [7:0] d);
		int unsigned diff;
		diff = (shadow_b ^ d) & 'h3E;
		if (diff == 0) return;
		shadow_b = (shadow_b & 'hC1) | (d & 'h3E);
		if (diff & 'h20) write_strobe(d);
		if (diff & 'h10) read_strobe(d);
	endfunction

	function void note_input(logic [2:0] req, logic [79:0] td);
		case (req)
			REQ_PA: latch_a = td[7:0];
			REQ_PB: port_b_write(td[7:0]);
			REQ_POS: begin
				range_x = td[55:40];
				range_y = td[71:56];
				place(td[23:8], td[39:24]);
				mouse_event();
			end
			REQ_BTN: begin
				if (td[73]) btn_now |= (td[72] ? 2 : 1);
				else btn_now &= (td[72] ? 1 : 2);
				mouse_event();
			end
			REQ_VBL: begin
				if (td[74] != vbl_seen) begin
					vbl_seen = td[74];
					if (td[74]) mouse_event();
				end
			end
			REQ_RST: soft_reset();
			default: ;
		endcase
		expected_q.push_back({4'b0, irq[0], shadow_b[3:1], shadow_b[7:0], drive_a[7:0]});
	endfunction

	function void check_result(logic [23:0] act);
		logic [23:0] exp_r;
		if (expected_q.size() == 0) begin
			$error("unexpected result transaction %h", act);
			errors++;
			return;
		end
		exp_r = expected_q.pop_front();
		if (act[7:0] !== exp_r[7:0]) begin
			$error("port_a_out expected %h actual %h", exp_r[7:0], act[7:0]);
			errors++;
		end
		if (act[15:8] !== exp_r[15:8]) begin
			$error("port_b_out expected %h actual %h", exp_r[15:8], act[15:8]);
			errors++;
		end
		if (act[18:16] !== exp_r[18:16]) begin
			$error("rom_bank expected %h actual %h", exp_r[18:16], act[18:16]);
			errors++;
		end
		if (act[19] !== exp_r[19]) begin
			$error("irq_level expected %h actual %h", exp_r[19], act[19]);
			errors++;
		end
	endfunction
endclass

module tb_pia_mouse_controller;
	localparam int Limit = 1000000;

	logic clk, arst_n;
	logic s_axis_tvalid, s_axis_tready;
	logic [79:0] s_axis_tdata;
	logic [2:0] s_axis_tuser;
	logic m_axis_tvalid, m_axis_tready;
	logic [23:0] m_axis_tdata;

	pmc_scoreboard sb;
	int n_items;
	bit calm;
	bit [2:0] rom_sel;
	bit rd_hi;

	pia_mouse_controller dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	function automatic logic [79:0] pack(logic [7:0] d, logic [15:0] x, logic [15:0] y,
			logic [15:0] rx, logic [15:0] ry, logic bi, logic bd, logic vb);
		return {5'b0, vb, bd, bi, ry, rx, y, x, d};
	endfunction

	task automatic send(logic [2:0] req, logic [79:0] td);
		int gap;
		gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= td;
		s_axis_tuser <= req;
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
		sb.note_input(req, td);
		n_items++;
	endtask

	task automatic send_byte(logic [2:0] req, logic [7:0] d);
		send(req, pack(d, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			1'($urandom), 1'($urandom), 1'($urandom)));
	endtask

	task automatic pb_strobe(bit wr, bit level);
		logic [7:0] d;
		d = {2'($urandom), wr ? level : 1'b1, wr ? rd_hi : level, rom_sel, 1'($urandom)};
		if (!wr) rd_hi = level;
		send_byte(REQ_PB, d);
	endtask

	task automatic write_cmd_byte(logic [7:0] b);
		send_byte(REQ_PA, b);
		pb_strobe(1'b1, 1'b1);
		pb_strobe(1'b1, 1'b0);
	endtask

	task automatic read_step();
		pb_strobe(1'b0, 1'b1);
		pb_strobe(1'b0, 1'b0);
	endtask

	task automatic host_pos(logic [15:0] x, logic [15:0] y, logic [15:0] rx, logic [15:0] ry);
		send(REQ_POS, pack(8'($urandom), x, y, rx, ry, 1'($urandom), 1'($urandom),
			1'($urandom)));
	endtask

	function automatic logic [15:0] pick_range();
		case ($urandom_range(0, 4))
			0: return 16'd0;
			1: return 16'd1;
			2: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		int stall;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 19);
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk)
		if (arst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);

	initial begin
		repeat (Limit) @(posedge clk);
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		logic [7:0] cb;
		int nb;
		logic [7:0] clamp_seq [5];
		sb = new();
		n_items = 0;
		calm = 0;
		rom_sel = 0;
		rd_hi = 1;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = REQ_PA;
		clamp_seq = '{8'h61, 8'h00, 8'h02, 8'h00, 8'h01};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed
		send_byte(REQ_PA, 8'h00);
		send_byte(REQ_PA, 8'hFF);
		send_byte(REQ_PB, 8'h40);
		host_pos(16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF);
		host_pos(16'hFFFF, 16'h0000, 16'h0001, 16'hFFFF);
		host_pos(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		rom_sel = 3'd7;
		write_cmd_byte(8'h0F);
		send(REQ_BTN, pack(8'h00, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1, 1'b0));
		send(REQ_BTN, pack(8'hFF, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1, 1'b1));
		send(REQ_VBL, pack(8'h00, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 1'b1));
		send(REQ_VBL, pack(8'h00, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0));
		write_cmd_byte(8'h10);
		repeat (6) read_step();
		write_cmd_byte(8'h20);
		read_step();
		foreach (clamp_seq[i])
			write_cmd_byte(clamp_seq[i]);
		send(3'd6, pack(8'h00, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0));
		send(3'd7, pack(8'hFF, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0));
		send_byte(REQ_RST, 8'h00);
		rom_sel = 3'd0;
		repeat (9) write_cmd_byte(8'hA5);

		// random
		while (n_items < 2000) begin
			if (n_items > 1800) calm = 1;
			rom_sel = 3'($urandom);
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: begin
					cb = {4'($urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 9)),
						4'($urandom)};
					nb = $urandom_range(0, 4) == 0 ? $urandom_range(1, 9) : 0;
					case (cb[7:4])
						4'h4, 4'h6: if (nb == 0) nb = 5;
						4'h5: if (nb == 0) nb = 3;
						default: if (nb == 0) nb = 1;
					endcase
					write_cmd_byte(cb);
					for (int i = 1; i < nb; i++)
						write_cmd_byte($urandom_range(0, 1) ? 8'($urandom) :
							8'($urandom_range(0, 4)));
					repeat ($urandom_range(0, 7)) read_step();
				end
				6: host_pos(16'($urandom), 16'($urandom), pick_range(), pick_range());
				7: send(REQ_BTN, pack(8'($urandom), 16'd0, 16'd0, 16'd0, 16'd0,
					1'($urandom), 1'($urandom), 1'b0));
				8: send(REQ_VBL, pack(8'($urandom), 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0,
					1'($urandom)));
				default: begin
					send(3'($urandom_range(0, 7)), pack(8'($urandom), 16'($urandom),
						16'($urandom), pick_range(), pick_range(), 1'($urandom),
						1'($urandom), 1'($urandom)));
					rd_hi = sb.shadow_b[4];
				end
			endcase
		end
		s_axis_tvalid <= 1'b0;

		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.expected_q.size() != 0) begin
			$error("%0d expected results never arrived", sb.expected_q.size());
			sb.errors++;
		end
		if (sb.errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end
endmodule
`default_nettype wire

// ----- filelist.f -----
hw/rtl/pmc_pkg.sv
hw/rtl/pmc_ctrl.sv
hw/rtl/pmc_dp.sv
hw/rtl/pia_mouse_controller.sv
tb/tb_pia_mouse_controller.sv
